FILE: hw/rtl/sset_pkg.sv
// Shared types, codes and constants for the sorted set block.
package sset_pkg;

	// Default number of cells in the chain
	localparam int CAPACITY_DEF = 32;
	// Most elements streamed by one dump
	localparam int MAX_RESULTS = 32;
	// Width of one stored element
	localparam int VAL_W = 32;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_DUMP   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_DONE     = 2'd0,
		STAT_DUP      = 2'd1,
		STAT_NOTFOUND = 2'd2,
		STAT_FULL     = 2'd3
	} status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_DUMP = 1'b1
	} state_t;

	// Per-cycle operation broadcast to every cell
	typedef struct packed {
		logic ins;
		logic del;
		logic rot;
	} cell_ctl_t;

endpackage

FILE: hw/rtl/sset_cell.sv
// One compare-and-shift cell of the sorted chain.
module sset_cell (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sset_pkg::cell_ctl_t                ctl,
	input  logic signed [sset_pkg::VAL_W-1:0]  op_value,
	input  logic signed [sset_pkg::VAL_W-1:0]  head_value,
	input  logic signed [sset_pkg::VAL_W-1:0]  left_value,
	input  logic                               left_valid,
	input  logic                               left_lt,
	input  logic signed [sset_pkg::VAL_W-1:0]  right_value,
	input  logic                               right_valid,
	output logic signed [sset_pkg::VAL_W-1:0]  value,
	output logic                               valid,
	output logic                               lt,
	output logic                               eq
);
	import sset_pkg::*;

	logic signed [VAL_W-1:0] value_q;
	logic signed [VAL_W-1:0] value_d;
	logic                    valid_q;
	logic                    valid_d;

	// Compare the held element against the operand
	assign lt    = valid_q && (value_q < op_value);
	assign eq    = valid_q && (value_q == op_value);
	assign value = value_q;
	assign valid = valid_q;

	// Pick the next element: keep, take operand, shift in from a neighbor, rotate
	always_comb begin
		value_d = value_q;
		valid_d = valid_q;
		if (ctl.ins && !lt) begin
			value_d = left_lt ? op_value : left_value;
			valid_d = valid_q | left_valid;
		end else if (ctl.del && !lt) begin
			value_d = right_value;
			valid_d = right_valid;
		end else if (ctl.rot && valid_q) begin
			value_d = right_valid ? right_value : head_value;
		end
	end

	// Hold the element
	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	// Hold the occupancy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

endmodule

FILE: hw/rtl/sorted_set_insert_delete.sv
// Insert, delete and empty dump give their result in the cycle after acceptance;
//   a non-empty dump enters the dump state, then registers one element per step.
// Flow: a new command is taken only when idle and the result register is free;
//   a dump holds the input while the cell chain rotates once per element, one
//   rotation and one streamed element per cycle while the output is taken.
// Reset: asynchronous; empties the set (all cell occupancy flags cleared, count zero).
module sorted_set_insert_delete #(
	parameter int CAPACITY = sset_pkg::CAPACITY_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         cmd,
	input  logic signed [sset_pkg::VAL_W-1:0]  value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [sset_pkg::VAL_W-1:0]  item_value,
	output logic                               has_item,
	output logic [5:0]                         set_count,
	output logic [1:0]                         status,
	output logic                               last
);
	import sset_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic signed [VAL_W-1:0] cell_val [CAPACITY];
	logic [CAPACITY-1:0]     cell_vld;
	logic [CAPACITY-1:0]     cell_lt;
	logic [CAPACITY-1:0]     cell_eq;
	cell_ctl_t               ctl;

	state_t                  state_q;
	state_t                  state_d;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        count_d;
	logic [CNT_W-1:0]        idx_q;
	logic [CNT_W-1:0]        idx_d;

	logic                    out_valid_q;
	logic signed [VAL_W-1:0] item_value_q;
	logic                    has_item_q;
	logic [5:0]              set_count_q;
	logic [1:0]              status_q;
	logic                    last_q;

	logic                    out_load;
	logic signed [VAL_W-1:0] item_value_d;
	logic                    has_item_d;
	logic [1:0]              status_d;
	logic                    last_d;

	logic                    accept;
	logic                    out_free;
	logic                    found;
	logic                    full;
	logic                    emit_now;
	logic                    step;
	logic [6:0]              count7;
	logic [6:0]              count_d7;
	logic [6:0]              idx7;
	logic [6:0]              lim7;

	// Build the chain of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VAL_W-1:0] lval;
		logic                    lvld;
		logic                    llt;
		logic signed [VAL_W-1:0] rval;
		logic                    rvld;

		if (i == 0) begin : g_first
			assign lval = value;
			assign lvld = 1'b1;
			assign llt  = 1'b1;
		end else begin : g_mid_l
			assign lval = cell_val[i-1];
			assign lvld = cell_vld[i-1];
			assign llt  = cell_lt[i-1];
		end

		if (i == CAPACITY - 1) begin : g_end
			assign rval = cell_val[0];
			assign rvld = 1'b0;
		end else begin : g_mid_r
			assign rval = cell_val[i+1];
			assign rvld = cell_vld[i+1];
		end

		sset_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.op_value    (value),
			.head_value  (cell_val[0]),
			.left_value  (lval),
			.left_valid  (lvld),
			.left_lt     (llt),
			.right_value (rval),
			.right_valid (rvld),
			.value       (cell_val[i]),
			.valid       (cell_vld[i]),
			.lt          (cell_lt[i]),
			.eq          (cell_eq[i])
		);
	end

	// Gather match and occupancy information
	assign found    = |cell_eq;
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign accept   = in_valid && in_ready;

	// Dump bookkeeping in a fixed 7-bit width
	assign count7   = 7'(count_q);
	assign idx7     = 7'(idx_q);
	assign lim7     = (count7 > 7'(MAX_RESULTS)) ? 7'(MAX_RESULTS) : count7;
	assign emit_now = idx7 < lim7;
	assign step     = (state_q == ST_DUMP) && (!emit_now || out_free);

	// Decode the transaction, drive the cells and the result register
	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		idx_d        = idx_q;
		ctl          = '0;
		out_load     = 1'b0;
		item_value_d = '0;
		has_item_d   = 1'b0;
		status_d     = STAT_DONE;
		last_d       = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					out_load = 1'b1;
					case (cmd_t'(cmd))
						CMD_INSERT: begin
							if (found) begin
								status_d = STAT_DUP;
							end else if (full) begin
								status_d = STAT_FULL;
							end else begin
								ctl.ins = 1'b1;
								count_d = count_q + 1'b1;
							end
						end
						CMD_DELETE: begin
							if (found) begin
								ctl.del = 1'b1;
								count_d = count_q - 1'b1;
							end else begin
								status_d = STAT_NOTFOUND;
							end
						end
						CMD_DUMP: begin
							if (count_q != '0) begin
								out_load = 1'b0;
								state_d  = ST_DUMP;
								idx_d    = '0;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_DUMP: begin
				if (step) begin
					ctl.rot      = 1'b1;
					out_load     = emit_now;
					item_value_d = cell_val[0];
					has_item_d   = 1'b1;
					last_d       = (idx7 + 7'd1 == lim7);
					idx_d        = idx_q + 1'b1;
					if (idx7 + 7'd1 == count7) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Saturate the reported count at 63
	assign count_d7 = 7'(count_d);

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the result payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			item_value_q <= item_value_d;
			has_item_q   <= has_item_d;
			set_count_q  <= (count_d7 > 7'd63) ? 6'd63 : count_d7[5:0];
			status_q     <= status_d;
			last_q       <= last_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign item_value = item_value_q;
	assign has_item   = has_item_q;
	assign set_count  = set_count_q;
	assign status     = status_q;
	assign last       = last_q;

	// Occupied cells always match the element count
	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_vld) == int'(count_q))
		else $error("cell occupancy disagrees with element count");

	// Occupied cells form a prefix of the chain
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((cell_vld & (cell_vld + 1'b1)) == '0))
		else $error("occupied cells are not contiguous from the head");

	// Dump index stays inside the set
	a_dump_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DUMP) |-> (idx_q < count_q))
		else $error("dump index ran past the element count");

	// A fresh insert grows the set by one
	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == CMD_INSERT && !found && !full) |=> (count_q == $past(count_q) + 1'b1))
		else $error("insert did not grow the set");

endmodule

FILE: tb/tb.sv
// Testbench for the sorted set block: directed and random commands against a scoreboard.
`timescale 1ns / 100ps

module tb;
	import sset_pkg::*;

	localparam int CAP = CAPACITY_DEF;
	localparam int TOP_VAL = 2147483647;
	localparam int BOTTOM_VAL = -2147483647;
	localparam int RAW_MIN = -2147483647 - 1;

	typedef struct {
		int         item_value;
		logic       has_item;
		logic [5:0] set_count;
		status_t    status;
		logic       last;
	} set_result_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic [1:0]                cmd;
	logic signed [VAL_W-1:0]   value;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [VAL_W-1:0]   item_value;
	logic                      has_item;
	logic [5:0]                set_count;
	logic [1:0]                status;
	logic                      last;

	// Shadow copy of the set, ascending
	int set_vals [CAP];
	int set_size;
	set_result_t pending_results [$];

	int errors;
	int burst_left;
	int gap_max;
	int stall_max;

	sorted_set_insert_delete #(
		.CAPACITY(CAP)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.item_value(item_value),
		.has_item  (has_item),
		.set_count (set_count),
		.status    (status),
		.last      (last)
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// End a hung run
	initial begin
		#10_000_000;
		$display("sorted_set_insert_delete: mismatch");
		$finish;
	end

	// Update the shadow set for one command and queue the results it yields
	function automatic void apply_command(logic [1:0] c, int v);
		set_result_t r;
		int pos;
		int i;
		int n;
		r.item_value = 0;
		r.has_item = 1'b0;
		r.status = STAT_DONE;
		r.last = 1'b1;
		pos = 0;
		while (pos < set_size && set_vals[pos] < v)
			pos++;
		case (c)
			CMD_INSERT: begin
				if (pos < set_size && set_vals[pos] == v) begin
					r.status = STAT_DUP;
				end else if (set_size >= CAP) begin
					r.status = STAT_FULL;
				end else begin
					for (i = set_size; i > pos; i--)
						set_vals[i] = set_vals[i-1];
					set_vals[pos] = v;
					set_size++;
				end
			end
			CMD_DELETE: begin
				if (pos < set_size && set_vals[pos] == v) begin
					for (i = pos; i < set_size - 1; i++)
						set_vals[i] = set_vals[i+1];
					set_size--;
				end else begin
					r.status = STAT_NOTFOUND;
				end
			end
			CMD_DUMP: begin
				if (set_size > 0) begin
					n = (set_size > MAX_RESULTS) ? MAX_RESULTS : set_size;
					r.set_count = (set_size > 63) ? 6'd63 : 6'(set_size);
					for (i = 0; i < n; i++) begin
						r.item_value = set_vals[i];
						r.has_item = 1'b1;
						r.last = (i == n - 1);
						pending_results.push_back(r);
					end
					return;
				end
			end
			default: ;
		endcase
		r.set_count = (set_size > 63) ? 6'd63 : 6'(set_size);
		pending_results.push_back(r);
	endfunction

	// Predict on input transactions, then compare output transactions in order
	always @(posedge clk) begin : check_results
		set_result_t exp_r;
		if (arst_n) begin
			if (in_valid && in_ready)
				apply_command(cmd, value);
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result: item_value %0d status %0d", item_value, status);
					errors++;
				end else begin
					exp_r = pending_results.pop_front();
					if (item_value !== exp_r.item_value) begin
						$error("item_value: expected %0d, got %0d", exp_r.item_value, item_value);
						errors++;
					end
					if (has_item !== exp_r.has_item) begin
						$error("has_item: expected %0d, got %0d", exp_r.has_item, has_item);
						errors++;
					end
					if (set_count !== exp_r.set_count) begin
						$error("set_count: expected %0d, got %0d", exp_r.set_count, set_count);
						errors++;
					end
					if (status !== exp_r.status) begin
						$error("status: expected %0d, got %0d", exp_r.status, status);
						errors++;
					end
					if (last !== exp_r.last) begin
						$error("last: expected %0d, got %0d", exp_r.last, last);
						errors++;
					end
				end
			end
		end
	end

	// Receiver: alternate ready runs with random-length stalls bounded by stall_max
	initial begin : drive_out_ready
		int left;
		bit hold_low;
		left = 0;
		hold_low = 1'b1;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				hold_low = !hold_low && (stall_max > 0);
				left = hold_low ? $urandom_range(1, stall_max) : $urandom_range(1, 12);
				out_ready <= !hold_low;
			end
			left--;
		end
	end

	// Send one transaction; open a gap between bursts
	task automatic send_cmd(cmd_t c, int v);
		int gap;
		if (burst_left == 0) begin
			gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		in_valid <= 1'b1;
		cmd <= c;
		value <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		burst_left--;
	endtask

	// Pick an operand: a member, a boundary value, a narrow value or a wide one
	function automatic int choose_operand(int member_pct, bit narrow);
		int extremes [6];
		extremes = '{TOP_VAL, BOTTOM_VAL, RAW_MIN, 0, -1, 1};
		if (set_size > 0 && $urandom_range(0, 99) < member_pct)
			return set_vals[$urandom_range(0, set_size - 1)];
		if (narrow)
			return int'($urandom_range(0, 12)) - 6;
		if ($urandom_range(0, 9) == 0)
			return extremes[$urandom_range(0, 5)];
		return int'($urandom);
	endfunction

	task automatic run_random_phase(int n, int w_ins, int w_del, int w_dump,
			int member_pct, bit narrow);
		int r;
		cmd_t c;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < w_ins)
				c = CMD_INSERT;
			else if (r < w_ins + w_del)
				c = CMD_DELETE;
			else if (r < w_ins + w_del + w_dump)
				c = CMD_DUMP;
			else
				c = CMD_NONE;
			send_cmd(c, choose_operand(member_pct, narrow));
		end
	endtask

	// Commands on an empty set
	task automatic test_empty_set();
		gap_max = 1;
		stall_max = 3;
		send_cmd(CMD_DUMP, 0);
		send_cmd(CMD_DELETE, 0);
		send_cmd(CMD_NONE, int'($urandom));
	endtask

	// Boundary values, duplicates, absent deletes and the unused code
	task automatic test_extreme_values();
		send_cmd(CMD_INSERT, TOP_VAL);
		send_cmd(CMD_INSERT, BOTTOM_VAL);
		send_cmd(CMD_INSERT, RAW_MIN);
		send_cmd(CMD_INSERT, 0);
		send_cmd(CMD_INSERT, 0);
		send_cmd(CMD_INSERT, -1);
		send_cmd(CMD_DUMP, int'($urandom));
		send_cmd(CMD_DELETE, 5);
		send_cmd(CMD_DELETE, RAW_MIN);
		send_cmd(CMD_DELETE, TOP_VAL);
		send_cmd(CMD_NONE, -1);
		send_cmd(CMD_DUMP, 0);
		send_cmd(CMD_DELETE, BOTTOM_VAL);
		send_cmd(CMD_DELETE, 0);
		send_cmd(CMD_DELETE, -1);
		send_cmd(CMD_DUMP, 0);
	endtask

	// Mostly inserts of wide values: reach capacity and hit the full case
	task automatic test_fill_to_capacity();
		gap_max = 3;
		stall_max = 4;
		run_random_phase(70, 85, 5, 8, 10, 1'b0);
	endtask

	// Near capacity with no idling: duplicates while full, full dumps
	task automatic test_full_churn();
		gap_max = 0;
		stall_max = 0;
		run_random_phase(60, 50, 20, 25, 50, 1'b0);
	endtask

	// Mostly deletes of members down to an empty set, with long stalls
	task automatic test_drain();
		gap_max = 6;
		stall_max = 8;
		run_random_phase(70, 10, 75, 12, 85, 1'b0);
	endtask

	// Narrow value range: frequent hits, misses and duplicates
	task automatic test_narrow_mix();
		gap_max = 2;
		stall_max = 2;
		run_random_phase(70, 35, 35, 20, 30, 1'b1);
	endtask

	// Sequence the tests and report
	initial begin : run_tests
		int wait_cycles;
		errors = 0;
		burst_left = 0;
		gap_max = 0;
		stall_max = 0;
		set_size = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		cmd <= CMD_NONE;
		value <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_set();
		test_extreme_values();
		test_fill_to_capacity();
		test_full_churn();
		test_drain();
		test_narrow_mix();
		in_valid <= 1'b0;

		// Drain outstanding results, then allow stray ones to show up
		wait_cycles = 0;
		while (pending_results.size() != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (10) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			errors++;
		end

		if (errors == 0)
			$display("sorted_set_insert_delete: match");
		else
			$display("sorted_set_insert_delete: mismatch");
		$finish;
	end

endmodule
